>>> design/tlt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the two-line text terminal refresh unit.
package tlt_pkg;

    localparam int LINE_CHARS_DEFAULT = 16;

    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TERM   = 8'h00;
    localparam logic [7:0] GLYPH_RESET = 8'hFF;

    // Status from the screen scanner to the control
    typedef struct packed {
        logic scanning;
        logic last_taken;
    } scan_stat_t;

endpackage

>>> design/tlt_line_mem.sv
`timescale 1ns / 1ps
// Line store: synchronous memory with per-entry valid bits, unwritten entries read as space.
module tlt_line_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    import tlt_pkg::*;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [7:0]       q_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : CHAR_SPACE;

endmodule

>>> design/tlt_screen_scan.sv
`timescale 1ns / 1ps
// Screen scanner: reads both lines cell by cell and formats the output items.
module tlt_screen_scan #(
    parameter int LINE_CHARS = 16,
    parameter int IDX_W      = 4,
    parameter int ADDR_W     = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [IDX_W-1:0]   cursor,
    input  logic               active_row,
    input  logic [7:0]         cursor_glyph,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [7:0]         rd_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               row,
    output logic [3:0]         column,
    output logic [7:0]         glyph,
    output logic               last_of_screen,
    output tlt_pkg::scan_stat_t stat
);
    import tlt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_CHARS - 1);

    logic             scan_reg, scan_next;
    logic             srow_reg, srow_next;
    logic [IDX_W-1:0] sidx_reg, sidx_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_row_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_last_reg;
    logic             ended_reg, ended_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_row_reg;
    logic [3:0]       out_col_reg;
    logic [7:0]       out_glyph_reg, out_glyph_next;
    logic             out_last_reg;
    logic             out_load;
    logic             s1_move;
    logic             line_sel;
    logic [IDX_W+3:0] idx_ext;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_load;
    assign rd_en    = scan_reg && (!s1_valid_reg || out_load);
    assign line_sel = srow_reg ? active_row : !active_row;
    assign rd_addr  = line_sel ? ADDR_W'(LINE_CHARS) + ADDR_W'(sidx_reg) : ADDR_W'(sidx_reg);
    assign idx_ext  = {4'b0000, s1_idx_reg};

    always_comb
    begin
        scan_next = scan_reg;
        srow_next = srow_reg;
        sidx_next = sidx_reg;
        if (start)
        begin
            scan_next = 1'b1;
            srow_next = 1'b0;
            sidx_next = '0;
        end
        else if (rd_en)
        begin
            if (sidx_reg == LAST_IDX)
            begin
                sidx_next = '0;
                srow_next = 1'b1;
                if (srow_reg)
                begin
                    scan_next = 1'b0;
                end
            end
            else
            begin
                sidx_next = sidx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Row 0 blanks from the first terminator on; row 1 shows up to the cursor
    always_comb
    begin
        ended_next     = ended_reg;
        out_glyph_next = CHAR_SPACE;
        if (!s1_row_reg)
        begin
            if (ended_reg || rd_data == CHAR_TERM)
            begin
                out_glyph_next = CHAR_SPACE;
            end
            else
            begin
                out_glyph_next = rd_data;
            end
            if (s1_move && rd_data == CHAR_TERM)
            begin
                ended_next = 1'b1;
            end
        end
        else
        begin
            if (s1_idx_reg < cursor)
            begin
                out_glyph_next = rd_data;
            end
            else if (s1_idx_reg == cursor)
            begin
                out_glyph_next = cursor_glyph;
            end
        end
        if (start)
        begin
            ended_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= 1'b0;
            srow_reg      <= 1'b0;
            sidx_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            srow_reg      <= srow_next;
            sidx_reg      <= sidx_next;
            s1_valid_reg  <= s1_valid_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_row_reg  <= srow_reg;
            s1_idx_reg  <= sidx_reg;
            s1_last_reg <= srow_reg && (sidx_reg == LAST_IDX);
        end
        if (s1_move)
        begin
            out_row_reg   <= s1_row_reg;
            out_col_reg   <= idx_ext[3:0];
            out_glyph_reg <= out_glyph_next;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign row             = out_row_reg;
    assign column          = out_col_reg;
    assign glyph           = out_glyph_reg;
    assign last_of_screen  = out_last_reg;
    assign stat.scanning   = scan_reg;
    assign stat.last_taken = out_valid_reg && !out_stall && out_last_reg;

endmodule

>>> design/two_line_text_terminal_refresh_unit.sv
`timescale 1ns / 1ps
// Top level: cursor and line control around the line store and the screen scanner.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_stall | char_in
//  out     | out_valid/out_stall | row, column, glyph, last_of_screen
//  cfg     | cfg_valid/cfg_ready | cfg_data (cursor glyph)
//
// An item is written into the line store in its accept cycle, then the screen
// is read back one cell per cycle while the output does not stall, through the
// registered memory read port.
// The next item is taken once the last cell of the screen has been delivered.
// Reset marks every line store entry unwritten (reads as space), cursor 0, row 0.
// An output stall holds the output register and backs up the memory reads.
module two_line_text_terminal_refresh_unit #(
    parameter int LINE_CHARS = tlt_pkg::LINE_CHARS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       row,
    output logic [3:0] column,
    output logic [7:0] glyph,
    output logic       last_of_screen,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import tlt_pkg::*;

    localparam int IDX_W  = $clog2(LINE_CHARS);
    localparam int ADDR_W = $clog2(2 * LINE_CHARS);
    localparam int DEPTH  = 2 * LINE_CHARS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic             active_reg, active_next;
    logic [7:0]       glyph_cfg_reg, glyph_cfg_next;
    logic             accept;
    logic [IDX_W:0]   cur_inc;
    logic             wrap;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    scan_stat_t       stat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = in_valid && !in_stall;

    assign wr_addr = active_reg ? ADDR_W'(LINE_CHARS) + ADDR_W'(cursor_reg)
                                : ADDR_W'(cursor_reg);
    assign wr_data = (char_in == CHAR_CR) ? CHAR_TERM : char_in;
    assign cur_inc = {1'b0, cursor_reg} + 1'b1;
    assign wrap    = (cur_inc == (IDX_W + 1)'(LINE_CHARS)) || (char_in == CHAR_CR);

    always_comb
    begin
        cursor_next    = cursor_reg;
        active_next    = active_reg;
        glyph_cfg_next = glyph_cfg_reg;
        if (accept)
        begin
            if (wrap)
            begin
                cursor_next = '0;
                active_next = !active_reg;
            end
            else
            begin
                cursor_next = cur_inc[IDX_W-1:0];
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            glyph_cfg_next = cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.scanning)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.last_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            active_reg    <= 1'b0;
            glyph_cfg_reg <= GLYPH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            active_reg    <= active_next;
            glyph_cfg_reg <= glyph_cfg_next;
        end
    end

    tlt_line_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Scan starts the cycle after the write, so reads see the new character
    tlt_screen_scan #(
        .LINE_CHARS (LINE_CHARS),
        .IDX_W      (IDX_W),
        .ADDR_W     (ADDR_W)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept),
        .cursor         (cursor_next),
        .active_row     (active_next),
        .cursor_glyph   (glyph_cfg_reg),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row            (row),
        .column         (column),
        .glyph          (glyph),
        .last_of_screen (last_of_screen),
        .stat           (stat)
    );

    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !out_valid)
        else $error("output item while idle");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (IDX_W + 1)'(cursor_reg) < (IDX_W + 1)'(LINE_CHARS))
        else $error("cursor beyond line");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_SCAN && stat.scanning)
        else $error("accepted item did not start a scan");

    a_last_on_row1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_screen |-> row && state_reg == ST_DRAIN)
        else $error("last cell out of place");

endmodule

>>> test/tlt_screen_checker.sv
`timescale 1ns / 1ps
// Screen checker: tracks the line stores and compares every refreshed cell.
module tlt_screen_checker
    import tlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       row,
    input  logic [3:0] column,
    input  logic [7:0] glyph,
    input  logic       last_of_screen,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         cells_pending
);

    localparam int LINE_CHARS = LINE_CHARS_DEFAULT;

    typedef struct packed {
        logic       row;
        logic [3:0] column;
        logic [7:0] code;
        logic       last_cell;
    } screen_cell_t;

    screen_cell_t expected_cells [$];

    logic [7:0] lines [2][LINE_CHARS];
    int         cursor;
    logic       write_line;
    logic [7:0] cursor_glyph;

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Store the character, move the cursor, then queue the whole screen.
    task automatic predict_screen(input logic [7:0] ch);
        int         i;
        logic       prev;
        logic       ended;
        logic [7:0] g;
        if (cursor >= LINE_CHARS)
            cursor = 0;
        lines[write_line][cursor] = (ch == CHAR_CR) ? CHAR_TERM : ch;
        cursor++;
        if (cursor >= LINE_CHARS || ch == CHAR_CR) begin
            cursor = 0;
            write_line = !write_line;
        end
        prev = !write_line;
        ended = 1'b0;
        for (i = 0; i < LINE_CHARS; i++) begin
            g = lines[prev][i];
            // everything from the first terminator on shows blank
            if (ended || g == CHAR_TERM) begin
                ended = 1'b1;
                g = CHAR_SPACE;
            end
            expected_cells.push_back('{1'b0, 4'(i), g, 1'b0});
        end
        for (i = 0; i < LINE_CHARS; i++) begin
            if (i < cursor)
                g = lines[write_line][i];
            else if (i == cursor)
                g = cursor_glyph;
            else
                g = CHAR_SPACE;
            expected_cells.push_back('{1'b1, 4'(i), g, (i == LINE_CHARS - 1)});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        screen_cell_t want;
        if (!rst_n) begin
            foreach (lines[r, c])
                lines[r][c] = CHAR_SPACE;
            cursor = 0;
            write_line = 1'b0;
            cursor_glyph = GLYPH_RESET;
            expected_cells.delete();
            mismatches = 0;
            cells_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                cursor_glyph = cfg_data;
            // compare before queueing, so a same-edge input lands behind the old screen
            if (out_valid && !out_stall) begin
                if (expected_cells.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected cell, expected none, actual %0h/%0h/%0h/%0h",
                             $time, row, column, glyph, last_of_screen);
                end else begin
                    want = expected_cells.pop_front();
                    report_field("row", want.row, row);
                    report_field("column", want.column, column);
                    report_field("glyph", want.code, glyph);
                    report_field("last_of_screen", want.last_cell, last_of_screen);
                end
            end
            if (in_valid && !in_stall)
                predict_screen(char_in);
            cells_pending <= expected_cells.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, character stimulus, stalls and the verdict.
module tb_top;
    import tlt_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 2 * LINE_CHARS_DEFAULT + 8;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_stall;
    logic       row;
    logic [3:0] column;
    logic [7:0] glyph;
    logic       last_of_screen;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int screen_mismatches;
    int cells_pending;
    int quiet_cycles = 0;
    bit idling_on = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int stall_left = 0;

    logic [7:0] directed_chars [$] = '{
        8'h41, 8'h42, CHAR_CR,
        CHAR_TERM, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01, 8'hFE,
        8'h78, 8'h78, 8'h78, 8'h78, 8'h78, 8'h78, 8'h78, 8'h78,
        CHAR_CR, CHAR_CR
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_line_text_terminal_refresh_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row            (row),
        .column         (column),
        .glyph          (glyph),
        .last_of_screen (last_of_screen),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    tlt_screen_checker screen_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row            (row),
        .column         (column),
        .glyph          (glyph),
        .last_of_screen (last_of_screen),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (screen_mismatches),
        .cells_pending  (cells_pending)
    );

    // Mostly text lines ended by carriage return, with zero bytes and raw bytes mixed in.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return CHAR_CR;
        if (pick < 16)
            return CHAR_TERM;
        if (pick < 30)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in <= ch;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_glyph(input logic [7:0] g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every queued cell has come out.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (cells_pending != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                holds_served++;
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("two_line_text_terminal_refresh_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_in = 8'h00;
        cfg_valid = 1'b0;
        cfg_data = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_glyph(8'h00);
        foreach (directed_chars[i])
            send_char(directed_chars[i]);

        drain();
        write_glyph(8'hFF);
        idling_on = 1'b1;
        repeat (70) send_char(random_char());

        // hold the receiver while the sender keeps offering, so the input backs up
        drain();
        write_glyph(8'($urandom_range(1, 254)));
        idling_on = 1'b0;
        hold_requests++;
        repeat (20) send_char(random_char());
        idling_on = 1'b1;
        repeat (50) send_char(random_char());

        drain();
        write_glyph(CHAR_SPACE);
        repeat (40) send_char(random_char());

        drain();
        write_glyph(8'h7E);
        idling_on = 1'b0;
        repeat (40) send_char(random_char());

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (screen_mismatches == 0 && cells_pending == 0)
            $display("two_line_text_terminal_refresh_unit test passed");
        else
            $display("two_line_text_terminal_refresh_unit test failed");
        $finish;
    end

endmodule

>>> two_line_text_terminal_refresh_unit.f
design/tlt_pkg.sv
design/tlt_line_mem.sv
design/tlt_screen_scan.sv
design/two_line_text_terminal_refresh_unit.sv
test/tlt_screen_checker.sv
test/tb_top.sv
